/* sv/lbf_pkg.sv */
// Shared types, codes and constants of the LED blink and fade channel engine.
`default_nettype none

package lbf_pkg;

  // Number of channel cells in the table.
  localparam int unsigned CHANNELS = 4;
  // Duty step of one fade update.
  localparam int unsigned STEP = 4;

  // Width of a period or countdown value in milliseconds.
  localparam int unsigned LBF_PER_W = 17;
  // Fade dividend is rate * 1000, the divisor is 2 * max(1, intensity / STEP).
  localparam int unsigned LBF_DVD_W = $clog2(255 * 1000 + 1);
  localparam int unsigned LBF_Q_MAX = (255 / STEP > 0) ? 255 / STEP : 1;
  localparam int unsigned LBF_DVS_W = $clog2(2 * LBF_Q_MAX + 1);

  // Command codes.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_BLINK   = 2'd1;
  localparam logic [1:0] CMD_FADE    = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  // Channel modes; blink and fade match their command codes.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_BLINK = 2'd1;
  localparam logic [1:0] MODE_FADE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_CONFIGURED = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_DUTY       = 2'd2;
  localparam logic [1:0] ST_STATIC     = 2'd3;

  // High voltage actions.
  localparam logic [1:0] HV_NONE    = 2'd0;
  localparam logic [1:0] HV_ENABLE  = 2'd1;
  localparam logic [1:0] HV_DISABLE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_GREEN_PIN = 1'b0;
  localparam logic CFG_RED_PIN   = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pin;
    logic [7:0] rate;
    logic [7:0] intensity;
    logic       level;
  } lbf_in_t;

  typedef struct packed {
    logic [7:0] out_pin;
    logic [7:0] duty;
    logic [1:0] status;
    logic [1:0] hv_action;
    logic       last;
  } lbf_out_t;

  // One channel entry as held by a cell.
  typedef struct packed {
    logic                 valid;
    logic [7:0]           pin;
    logic [1:0]           mode;
    logic [7:0]           intensity;
    logic [7:0]           duty;
    logic                 rising;
    logic [LBF_PER_W-1:0] period;
    logic [LBF_PER_W-1:0] countdown;
  } lbf_entry_t;

  localparam lbf_entry_t LBF_ENTRY_EMPTY = '{
    valid:     1'b0,
    pin:       8'hFF,
    mode:      MODE_NONE,
    intensity: 8'd0,
    duty:      8'd0,
    rising:    1'b1,
    period:    '0,
    countdown: '0
  };

  // Operation broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                 drop;
    logic                 load;
    logic                 tick;
    logic [7:0]           pin;
    logic [1:0]           mode;
    logic [7:0]           intensity;
    logic [LBF_PER_W-1:0] period;
  } lbf_ctrl_t;

endpackage

`default_nettype wire

/* sv/lbf_div.sv */
// Restoring divider, one quotient bit per cycle, for the fade period.
`default_nettype none

module lbf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lbf_pkg::LBF_DVD_W-1:0] dividend_i,
  input  wire logic [lbf_pkg::LBF_DVS_W-1:0] divisor_i,
  output logic                               done_o,
  output logic      [lbf_pkg::LBF_DVD_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(lbf_pkg::LBF_DVD_W + 1);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [lbf_pkg::LBF_DVS_W:0]     rem_q, rem_d;
  logic [lbf_pkg::LBF_DVD_W-1:0]   quo_q, quo_d;
  logic [lbf_pkg::LBF_DVS_W-1:0]   dvs_q, dvs_d;
  logic [lbf_pkg::LBF_DVS_W:0]     trial;
  logic                            fits;

  // The remainder stays below the divisor, so its low bits plus the next
  // dividend bit form the trial value.
  assign trial = {rem_q[lbf_pkg::LBF_DVS_W-1:0], quo_q[lbf_pkg::LBF_DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? trial - {1'b0, dvs_q} : trial;
      quo_d = {quo_q[lbf_pkg::LBF_DVD_W-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(lbf_pkg::LBF_DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* sv/lbf_cell.sv */
// One channel cell of the table: holds an entry, shifts, loads and ticks it.
`default_nettype none

module lbf_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lbf_pkg::lbf_ctrl_t  ctrl_i,
  input  wire lbf_pkg::lbf_entry_t nb_i,
  input  wire logic                kill_i,
  input  wire logic                prev_valid_i,
  input  wire logic                ack_i,
  output lbf_pkg::lbf_entry_t      entry_o,
  output logic                     kill_o,
  output logic                     pend_o
);

  lbf_pkg::lbf_entry_t entry_q, entry_d;
  logic                pend_q, pend_d;
  logic                removing;
  logic [8:0]          up_sum;
  logic [7:0]          step8;

  assign step8    = 8'(lbf_pkg::STEP);
  assign up_sum   = {1'b0, entry_q.duty} + {1'b0, step8};
  // A cell drops its entry if it holds the pin or a cell before it did.
  assign removing = ctrl_i.drop &
                    (kill_i | (entry_q.valid & (entry_q.pin == ctrl_i.pin)));

  always_comb begin
    entry_d = entry_q;
    pend_d  = pend_q & ~ack_i;
    if (removing) begin
      entry_d = nb_i;
    end else if (ctrl_i.load & prev_valid_i & ~entry_q.valid) begin
      entry_d           = lbf_pkg::LBF_ENTRY_EMPTY;
      entry_d.valid     = 1'b1;
      entry_d.pin       = ctrl_i.pin;
      entry_d.mode      = ctrl_i.mode;
      entry_d.intensity = ctrl_i.intensity;
      entry_d.period    = ctrl_i.period;
      entry_d.countdown = ctrl_i.period;
    end else if (ctrl_i.tick & entry_q.valid) begin
      if (entry_q.countdown <= lbf_pkg::LBF_PER_W'(1)) begin
        entry_d.countdown = entry_q.period;
        pend_d            = 1'b1;
        if (entry_q.mode == lbf_pkg::MODE_BLINK) begin
          entry_d.duty = (entry_q.duty == 8'd0) ? entry_q.intensity : 8'd0;
        end else if (entry_q.mode == lbf_pkg::MODE_FADE) begin
          if (entry_q.rising && (up_sum >= {1'b0, entry_q.intensity})) begin
            entry_d.duty   = entry_q.intensity;
            entry_d.rising = 1'b0;
          end else if (!entry_q.rising && (entry_q.duty <= step8)) begin
            entry_d.duty   = 8'd0;
            entry_d.rising = 1'b1;
          end else begin
            entry_d.duty = entry_q.rising ? up_sum[7:0] : entry_q.duty - step8;
          end
        end
      end else begin
        entry_d.countdown = entry_q.countdown - lbf_pkg::LBF_PER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= lbf_pkg::LBF_ENTRY_EMPTY;
      pend_q  <= 1'b0;
    end else begin
      entry_q <= entry_d;
      pend_q  <= pend_d;
    end
  end

  assign entry_o = entry_q;
  assign kill_o  = removing;
  assign pend_o  = pend_q;

endmodule

`default_nettype wire

/* sv/led_blink_fade_channel_engine.sv */
// Top level of the LED blink and fade channel engine.
// The engine keeps a compacted table of LED channels in a row of cells and
// reports duty changes. Commands arrive on a valid/ready input channel: a
// one millisecond tick, blink, fade, or release. Results leave on a
// valid/ready output channel; each carries a pin, a duty, a status, a high
// voltage action and a last flag on the final result of a command.
// One command is processed at a time. A release goes through the drop and
// result states, a blink through drop, load and result, and a fade also
// waits for the 18 step divider that derives the fade period. A tick scans
// and reports each expired channel in turn.
// Results go out through an output register, so a new command can be
// taken while the last result still waits for the receiver. When the
// receiver stalls, the sequencer holds its next result until the output
// register frees up. Reset empties the table and sets the green and red
// LED pins to 0 and 1. The pin registers are written through the write
// port with no handshake and are meant to change only while idle.
`default_nettype none

module led_blink_fade_channel_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lbf_pkg::lbf_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lbf_pkg::lbf_out_t     out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [7:0]       cfg_wdata_i
);

  localparam int unsigned Chn = lbf_pkg::CHANNELS;

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TICK = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_DROP = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_LOAD = 7'b0100000,
    S_RES  = 7'b1000000
  } state_e;

  state_e                                state_q, state_d;
  lbf_pkg::lbf_in_t                      cmd_q, cmd_d;
  lbf_pkg::lbf_out_t                     res_q, res_d;
  lbf_pkg::lbf_out_t                     out_q, out_d;
  logic                                  out_valid_q, out_valid_d;
  logic [lbf_pkg::LBF_PER_W-1:0]         per_q, per_d;
  logic [7:0]                            green_q, red_q;

  lbf_pkg::lbf_ctrl_t                    ctrl;
  lbf_pkg::lbf_entry_t                   ent [Chn];
  logic [Chn:0]                          kill;
  logic [Chn-1:0]                        pend;
  logic [Chn-1:0]                        lowest;
  logic [Chn-1:0]                        ack;
  logic                                  slot_free;
  logic                                  emit;
  logic                                  full;
  logic [7:0]                            sel_pin, sel_duty;

  logic                                  div_start, div_done;
  logic [lbf_pkg::LBF_DVD_W-1:0]         dividend, quot;
  logic [lbf_pkg::LBF_DVS_W-1:0]         divisor;
  logic [7:0]                            qsteps, qfix;
  logic [lbf_pkg::LBF_PER_W-1:0]         blink_per, fade_per;

  // The output register can take a result when empty or being drained.
  assign slot_free  = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign full       = ent[Chn-1].valid;

  // Period arithmetic. Blink is rate * 50 ms; fade is rate * 1000 divided by
  // twice the number of duty steps, at least one step.
  assign blink_per = lbf_pkg::LBF_PER_W'(cmd_q.rate) * lbf_pkg::LBF_PER_W'(50);
  assign qsteps    = 8'(cmd_q.intensity / lbf_pkg::STEP);
  assign qfix      = (qsteps == 8'd0) ? 8'd1 : qsteps;
  assign divisor   = lbf_pkg::LBF_DVS_W'({1'b0, qfix} << 1);
  assign dividend  = lbf_pkg::LBF_DVD_W'(cmd_q.rate) * lbf_pkg::LBF_DVD_W'(1000);
  assign fade_per  = quot[lbf_pkg::LBF_PER_W-1:0];
  assign div_start = (state_q == S_DROP) && (cmd_q.cmd == lbf_pkg::CMD_FADE);

  lbf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Operation broadcast to the cells.
  always_comb begin
    ctrl           = '0;
    ctrl.drop      = (state_q == S_DROP);
    ctrl.load      = (state_q == S_LOAD) && !full;
    ctrl.tick      = (state_q == S_TICK);
    ctrl.pin       = cmd_q.pin;
    ctrl.mode      = cmd_q.cmd;
    ctrl.intensity = cmd_q.intensity;
    ctrl.period    = per_q;
  end

  // The cell row. Each cell hands its entry down to the one before it on a
  // drop, and passes its occupancy and drop chain to the one after it.
  assign kill[0] = 1'b0;

  for (genvar j = 0; j < Chn; j++) begin : g_cell
    lbf_pkg::lbf_entry_t nb;
    logic                prev_valid;

    if (j == Chn - 1) begin : g_tail
      assign nb = lbf_pkg::LBF_ENTRY_EMPTY;
    end else begin : g_mid
      assign nb = ent[j+1];
    end

    if (j == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = ent[j-1].valid;
    end

    lbf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .nb_i         (nb),
      .kill_i       (kill[j]),
      .prev_valid_i (prev_valid),
      .ack_i        (ack[j]),
      .entry_o      (ent[j]),
      .kill_o       (kill[j+1]),
      .pend_o       (pend[j])
    );
  end

  // After a tick, expired channels are reported in table order, lowest
  // pending cell first.
  assign lowest = pend & (~pend + Chn'(1));
  assign emit   = (state_q == S_SCAN) && (pend != '0) && slot_free;
  assign ack    = emit ? lowest : '0;

  always_comb begin
    sel_pin  = 8'd0;
    sel_duty = 8'd0;
    for (int unsigned k = 0; k < Chn; k++) begin
      if (lowest[k]) begin
        sel_pin  = sel_pin | ent[k].pin;
        sel_duty = sel_duty | ent[k].duty;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    per_d       = per_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i;
          state_d = (in_data_i.cmd == lbf_pkg::CMD_TICK) ? S_TICK : S_DROP;
        end
      end
      S_TICK: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (pend == '0) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.out_pin     = sel_pin;
          out_d.duty        = sel_duty;
          out_d.status      = lbf_pkg::ST_DUTY;
          out_d.hv_action   = lbf_pkg::HV_NONE;
          out_d.last        = ((pend & ~lowest) == '0);
        end
      end
      S_DROP: begin
        res_d.out_pin = cmd_q.pin;
        res_d.last    = 1'b1;
        if (cmd_q.cmd == lbf_pkg::CMD_RELEASE) begin
          res_d.duty      = cmd_q.level ? 8'hFF : 8'd0;
          res_d.status    = lbf_pkg::ST_STATIC;
          res_d.hv_action = cmd_q.level ? lbf_pkg::HV_ENABLE : lbf_pkg::HV_DISABLE;
          state_d         = S_RES;
        end else if (cmd_q.cmd == lbf_pkg::CMD_FADE) begin
          state_d = S_DIV;
        end else begin
          per_d   = (blink_per == '0) ? lbf_pkg::LBF_PER_W'(1) : blink_per;
          state_d = S_LOAD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          per_d   = (fade_per == '0) ? lbf_pkg::LBF_PER_W'(1) : fade_per;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        res_d.duty = 8'd0;
        if (full) begin
          res_d.status    = lbf_pkg::ST_FULL;
          res_d.hv_action = lbf_pkg::HV_NONE;
        end else begin
          res_d.status    = lbf_pkg::ST_CONFIGURED;
          res_d.hv_action = ((cmd_q.pin == green_q) || (cmd_q.pin == red_q)) ?
                            lbf_pkg::HV_ENABLE : lbf_pkg::HV_NONE;
        end
        state_d = S_RES;
      end
      S_RES: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      green_q     <= 8'd0;
      red_q       <= 8'd1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == lbf_pkg::CFG_GREEN_PIN)) begin
        green_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == lbf_pkg::CFG_RED_PIN)) begin
        red_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
    per_q <= per_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
